[sv/ambient_light_lux_calc_defines.svh]
// Assertion helpers for the lux calculation block
`ifndef AMBIENT_LIGHT_LUX_CALC_DEFINES_SVH
`define AMBIENT_LIGHT_LUX_CALC_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define ALC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lux calc: same-cycle check failed");

// Next-cycle implication, checked while out of reset
`define ALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lux calc: next-cycle check failed");

`endif

[sv/alc_pkg.sv]
`timescale 1ns / 1ps

package alc_pkg;

	// Formula segment reported with each result
	typedef enum logic [2:0] {
		SEG_NONE = 3'd0,
		SEG_LOW  = 3'd1,
		SEG_MID  = 3'd2,
		SEG_HIGH = 3'd3,
		SEG_TOP  = 3'd4
	} seg_t;

	localparam int unsigned LUX_W   = 19;
	localparam int unsigned KA_W    = 27;
	localparam int unsigned KB_W    = 28;
	localparam int unsigned POW_W   = 16;
	localparam int unsigned ACC_Q   = 48;
	localparam logic [LUX_W-1:0] LUX_MAX = 19'h7ffff;

	// Segment coefficients in Q32
	localparam logic [KA_W-1:0] KA_LOW  = 27'd130567006;
	localparam logic [KB_W-1:0] KB_LOW  = 28'd266287972;
	localparam logic [KA_W-1:0] KA_MID  = 27'd96207267;
	localparam logic [KB_W-1:0] KB_MID  = 28'd133143986;
	localparam logic [KA_W-1:0] KA_HIGH = 27'd54975581;
	localparam logic [KB_W-1:0] KB_HIGH = 28'd65713000;
	localparam logic [KA_W-1:0] KA_TOP  = 27'd6270652;
	localparam logic [KB_W-1:0] KB_TOP  = 28'd4810363;

	// Broadband coefficient of a segment
	function automatic logic [KA_W-1:0] coef_a(input seg_t s);
		logic [KA_W-1:0] k;
		case (s)
			SEG_LOW:  k = KA_LOW;
			SEG_MID:  k = KA_MID;
			SEG_HIGH: k = KA_HIGH;
			SEG_TOP:  k = KA_TOP;
			default:  k = '0;
		endcase
		return k;
	endfunction

	// Infrared coefficient of a segment
	function automatic logic [KB_W-1:0] coef_b(input seg_t s);
		logic [KB_W-1:0] k;
		case (s)
			SEG_LOW:  k = KB_LOW;
			SEG_MID:  k = KB_MID;
			SEG_HIGH: k = KB_HIGH;
			SEG_TOP:  k = KB_TOP;
			default:  k = '0;
		endcase
		return k;
	endfunction

	// Table entry: x^1.4 in Q16 for x = xq / 2^16, via z = x^0.4 by bit search
	function automatic logic [POW_W-1:0] pow_entry(input logic [15:0] xq);
		logic [15:0] z;
		logic [15:0] t;
		logic [95:0] t5;
		logic [95:0] lim;
		logic [31:0] prod;
		z = '0;
		lim = (96'(xq) * 96'(xq)) << 48;
		for (int b = 15; b >= 0; b--) begin
			t = z | (16'd1 << b);
			t5 = 96'(t) * 96'(t) * 96'(t) * 96'(t) * 96'(t);
			if (t5 <= lim) begin
				z = t;
			end
		end
		prod = 32'(xq) * 32'(z) + 32'd32768;
		return prod[31:16];
	endfunction

endpackage

[sv/ambient_light_lux_calc.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload (lowest bit up)
// s_axis    in   s_tvalid/s_tready  s_tdata: broadband_count[15:0], infrared_count[31:16]
// m_axis    out  m_tvalid/m_tready  m_tdata: lux_q8[18:0], segment[21:19], zero[23:22]
//
// One beat per cycle enters while no stall holds the stages; the ratio divider retires
// four quotient bits per stage.
// Reset clears only the stage valid bits; the power table is a constant ROM with no fill.
// A stalled stage holds and the stages behind it close up any bubbles, so a new beat can be
// taken while a finished result waits at the output register, as long as a stage behind it is empty.

`include "ambient_light_lux_calc_defines.svh"

module ambient_light_lux_calc #(
	parameter int unsigned RATIO_FRAC_BITS   = 16,
	parameter int unsigned POWER_TABLE_DEPTH = 256,
	parameter int unsigned LUX_FRAC_BITS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // broadband_count[15:0], infrared_count[31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // lux_q8[18:0], segment[21:19], zero pad[23:22]
);

	localparam int unsigned RFB    = RATIO_FRAC_BITS;
	localparam int unsigned STEPS  = 4;
	localparam int unsigned NDIV   = (RFB + STEPS - 1) / STEPS;
	localparam int unsigned TWO_D  = 2 * POWER_TABLE_DEPTH;
	localparam int unsigned SCL_W  = $clog2(TWO_D);
	localparam int unsigned PRD_W  = RFB + SCL_W + 1;
	localparam int unsigned IDX_W  = $clog2(POWER_TABLE_DEPTH + 1);
	localparam int unsigned SH     = alc_pkg::ACC_Q - LUX_FRAC_BITS;
	localparam int unsigned ACC_W  = 61;
	localparam logic [SCL_W:0] SCL_D = (SCL_W + 1)'(POWER_TABLE_DEPTH);

	// ---------------- stage 1: capture counts, pick segment ----------------
	logic                          adv_s1;
	logic                          vld_s1;
	logic [15:0]                   bb_s1;
	logic [15:0]                   ir_s1;
	alc_pkg::seg_t                 seg_s1;
	logic [15:0]                   bb_in;
	logic [15:0]                   ir_in;
	alc_pkg::seg_t                 seg_in;

	assign bb_in = s_tdata[15:0];
	assign ir_in = s_tdata[31:16];

	// Compare counts against the ratio bounds exactly
	always_comb begin
		seg_in = alc_pkg::SEG_NONE;
		if (bb_in != 16'd0 && ir_in != 16'd0) begin
			if ({ir_in, 1'b0} <= {1'b0, bb_in}) begin
				seg_in = alc_pkg::SEG_LOW;
			end else if (23'(ir_in) * 23'd100 <= 23'(bb_in) * 23'd61) begin
				seg_in = alc_pkg::SEG_MID;
			end else if (19'(ir_in) * 19'd5 <= 19'(bb_in) * 19'd4) begin
				seg_in = alc_pkg::SEG_HIGH;
			end else if (20'(ir_in) * 20'd10 <= 20'(bb_in) * 20'd13) begin
				seg_in = alc_pkg::SEG_TOP;
			end
		end
	end

	// ---------------- stage 2: restoring divider, STEPS bits per stage ----------------
	logic            adv_s2     [NDIV];
	logic            vld_s2     [NDIV];
	logic [15:0]     rem_s2     [NDIV];
	logic [RFB-1:0]  q_s2       [NDIV];
	logic [15:0]     bb_s2      [NDIV];
	logic [15:0]     ir_s2      [NDIV];
	alc_pkg::seg_t   seg_s2     [NDIV];

	// later stage controls
	logic adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8;
	logic vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic           vld_pre;
		logic [15:0]    rem_pre;
		logic [RFB-1:0] q_pre;
		logic [15:0]    bb_pre;
		logic [15:0]    ir_pre;
		alc_pkg::seg_t  seg_pre;
		logic           adv_nxt;
		logic [15:0]    rem_nxt;
		logic [RFB-1:0] q_nxt;

		if (k == 0) begin : g_src0
			assign vld_pre = vld_s1;
			assign rem_pre = ir_s1;
			assign q_pre   = '0;
			assign bb_pre  = bb_s1;
			assign ir_pre  = ir_s1;
			assign seg_pre = seg_s1;
		end else begin : g_srck
			assign vld_pre = vld_s2[k-1];
			assign rem_pre = rem_s2[k-1];
			assign q_pre   = q_s2[k-1];
			assign bb_pre  = bb_s2[k-1];
			assign ir_pre  = ir_s2[k-1];
			assign seg_pre = seg_s2[k-1];
		end

		if (k == NDIV - 1) begin : g_last
			assign adv_nxt = adv_s3;
		end else begin : g_mid
			assign adv_nxt = adv_s2[k+1];
		end

		assign adv_s2[k] = !vld_s2[k] || adv_nxt;

		// Shift in one quotient bit per step
		always_comb begin
			logic [16:0] t;
			rem_nxt = rem_pre;
			q_nxt   = q_pre;
			for (int s = 0; s < STEPS; s++) begin
				if (k * STEPS + s < RFB) begin
					t = {rem_nxt, 1'b0};
					if (t >= {1'b0, bb_pre}) begin
						rem_nxt = 16'(t - {1'b0, bb_pre});
						q_nxt   = {q_nxt[RFB-2:0], 1'b1};
					end else begin
						rem_nxt = t[15:0];
						q_nxt   = {q_nxt[RFB-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (adv_s2[k]) begin
				vld_s2[k] <= vld_pre;
			end
		end

		always_ff @(posedge clk) begin
			if (adv_s2[k] && vld_pre) begin
				rem_s2[k] <= rem_nxt;
				q_s2[k]   <= q_nxt;
				bb_s2[k]  <= bb_pre;
				ir_s2[k]  <= ir_pre;
				seg_s2[k] <= seg_pre;
			end
		end
	end

	// ---------------- stage 3: table index from ratio ----------------
	logic [IDX_W-1:0] idx_s3;
	logic [15:0]      bb_s3;
	logic [15:0]      ir_s3;
	alc_pkg::seg_t    seg_s3;
	logic [PRD_W-1:0] idx_prod;
	logic [SCL_W:0]   idx_raw;
	logic [IDX_W-1:0] idx_nxt;

	assign idx_prod = PRD_W'(q_s2[NDIV-1]) * PRD_W'(TWO_D);
	assign idx_raw  = (SCL_W + 1)'(idx_prod >> RFB);
	assign idx_nxt  = (idx_raw > SCL_D) ? IDX_W'(POWER_TABLE_DEPTH) : idx_raw[IDX_W-1:0];

	// ---------------- stage 4: power table ROM ----------------
	logic [alc_pkg::POW_W-1:0] pow_rom [POWER_TABLE_DEPTH+1];
	logic [alc_pkg::POW_W-1:0] p_s4;
	logic [15:0]               bb_s4;
	logic [15:0]               ir_s4;
	alc_pkg::seg_t             seg_s4;

	for (genvar i = 0; i <= POWER_TABLE_DEPTH; i++) begin : g_rom
		localparam logic [15:0] XQ = 16'((i * 65536) / TWO_D);
		assign pow_rom[i] = alc_pkg::pow_entry(XQ);
	end

	// ---------------- stage 5: first products ----------------
	logic [42:0]   pa_s5;
	logic [43:0]   px_s5;
	alc_pkg::seg_t seg_s5;

	// ---------------- stage 6: second product for the power segment ----------------
	logic [42:0]   pa_s6;
	logic [59:0]   py_s6;
	alc_pkg::seg_t seg_s6;

	// ---------------- stage 7: signed sum in Q48 ----------------
	logic signed [ACC_W-1:0] acc_s7;
	alc_pkg::seg_t           seg_s7;

	// ---------------- stage 8: round, clamp, saturate ----------------
	logic [alc_pkg::LUX_W-1:0] lux_s8;
	alc_pkg::seg_t             seg_s8;
	logic [ACC_W-1:0]          rnd_sum;
	logic [ACC_W-1:0]          rnd_sh;
	logic [alc_pkg::LUX_W-1:0] lux_nxt;

	assign rnd_sum = {1'b0, acc_s7[ACC_W-2:0]} + (ACC_W'(1) << (SH - 1));
	assign rnd_sh  = rnd_sum >> SH;

	always_comb begin
		lux_nxt = '0;
		if (seg_s7 != alc_pkg::SEG_NONE && !acc_s7[ACC_W-1] && acc_s7 != '0) begin
			if (rnd_sh > ACC_W'(alc_pkg::LUX_MAX)) begin
				lux_nxt = alc_pkg::LUX_MAX;
			end else begin
				lux_nxt = rnd_sh[alc_pkg::LUX_W-1:0];
			end
		end
	end

	// Advance chain: a stage moves when empty or when the one ahead moves
	assign adv_s8   = !vld_s8 || m_tready;
	assign adv_s7   = !vld_s7 || adv_s8;
	assign adv_s6   = !vld_s6 || adv_s7;
	assign adv_s5   = !vld_s5 || adv_s6;
	assign adv_s4   = !vld_s4 || adv_s5;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s1   = !vld_s1 || adv_s2[0];
	assign s_tready = adv_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= s_tvalid;
			if (adv_s3) vld_s3 <= vld_s2[NDIV-1];
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
			if (adv_s8) vld_s8 <= vld_s7;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			bb_s1  <= bb_in;
			ir_s1  <= ir_in;
			seg_s1 <= seg_in;
		end
		if (adv_s3 && vld_s2[NDIV-1]) begin
			idx_s3 <= idx_nxt;
			bb_s3  <= bb_s2[NDIV-1];
			ir_s3  <= ir_s2[NDIV-1];
			seg_s3 <= seg_s2[NDIV-1];
		end
		if (adv_s4 && vld_s3) begin
			p_s4   <= pow_rom[idx_s3];
			bb_s4  <= bb_s3;
			ir_s4  <= ir_s3;
			seg_s4 <= seg_s3;
		end
		if (adv_s5 && vld_s4) begin
			pa_s5  <= 43'(alc_pkg::coef_a(seg_s4)) * 43'(bb_s4);
			if (seg_s4 == alc_pkg::SEG_LOW) begin
				px_s5 <= 44'(32'(bb_s4) * 32'(p_s4));
			end else begin
				px_s5 <= 44'(alc_pkg::coef_b(seg_s4)) * 44'(ir_s4);
			end
			seg_s5 <= seg_s4;
		end
		if (adv_s6 && vld_s5) begin
			pa_s6 <= pa_s5;
			if (seg_s5 == alc_pkg::SEG_LOW) begin
				py_s6 <= 60'(alc_pkg::KB_LOW) * 60'(px_s5[31:0]);
			end else begin
				py_s6 <= {px_s5, 16'b0};
			end
			seg_s6 <= seg_s5;
		end
		if (adv_s7 && vld_s6) begin
			acc_s7 <= $signed({2'b0, pa_s6, 16'b0}) - $signed({1'b0, py_s6});
			seg_s7 <= seg_s6;
		end
		if (adv_s8 && vld_s7) begin
			lux_s8 <= lux_nxt;
			seg_s8 <= seg_s7;
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = {2'b00, seg_s8, lux_s8};

	// Checks
	`ALC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_tvalid && s_tready, vld_s1)
	`ALC_ASSERT_NOW(a_div_operand_order, clk, arst_n, vld_s1 && seg_s1 == alc_pkg::SEG_LOW, ir_s1 < bb_s1)
	`ALC_ASSERT_NOW(a_none_is_dark, clk, arst_n, vld_s8 && seg_s8 == alc_pkg::SEG_NONE, lux_s8 == '0)

endmodule

[test/lux_scoreboard.sv]
`timescale 1ns / 1ps

module lux_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // broadband_count[15:0], infrared_count[31:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // lux_q8[18:0], segment[21:19], zero pad[23:22]
	output int          mismatches,
	output int          outstanding
);

	localparam int TAB_D = 256;
	localparam int RFRAC = 16;
	localparam int LFRAC = 8;
	localparam int MAX_REPORTS = 200;

	// Q32 coefficients: broadband and infrared weight of each segment
	localparam longint C1_BB = 130567006;
	localparam longint C1_IR = 266287972;
	localparam longint C2_BB = 96207267;
	localparam longint C2_IR = 133143986;
	localparam longint C3_BB = 54975581;
	localparam longint C3_IR = 65713000;
	localparam longint C4_BB = 6270652;
	localparam longint C4_IR = 4810363;
	localparam longint unsigned LUX_CEIL = 524287;

	typedef struct packed {
		logic [18:0]   lux;
		alc_pkg::seg_t seg;
	} lux_pred_t;

	logic [15:0] pow14_rom [0:TAB_D];
	lux_pred_t   lux_pred_q [$];
	int          reports = 0;

	// Build the ratio^1.4 table: z = x^0.4 by bit search, entry = x * z in Q16
	initial begin : build_pow14
		logic [127:0]    lim;
		logic [127:0]    t5;
		logic [15:0]     z;
		logic [15:0]     t;
		longint unsigned xq;
		for (int i = 0; i <= TAB_D; i++) begin
			xq = (longint'(i) << 16) / (2 * TAB_D);
			lim = (128'(xq) * 128'(xq)) << 48;
			z = '0;
			for (int b = 15; b >= 0; b--) begin
				t = z | (16'd1 << b);
				t5 = 128'(t) * 128'(t) * 128'(t) * 128'(t) * 128'(t);
				if (t5 <= lim) begin
					z = t;
				end
			end
			pow14_rom[i] = 16'((xq * z + 64'd32768) >> 16);
		end
	end

	// Lux and segment for one pair of channel counts
	function automatic lux_pred_t predict_lux(input logic [15:0] bb_cnt, input logic [15:0] ir_cnt);
		lux_pred_t       r;
		longint          b;
		longint          f;
		longint          acc;
		longint unsigned rq;
		longint unsigned idx;
		longint unsigned lux;
		b = bb_cnt;
		f = ir_cnt;
		acc = 0;
		r.seg = alc_pkg::SEG_NONE;
		r.lux = '0;
		if (b != 0 && f != 0) begin
			if (2 * f <= b) begin
				rq = (f << RFRAC) / b;
				idx = (rq * 2 * TAB_D) >> RFRAC;
				if (idx > TAB_D) begin
					idx = TAB_D;
				end
				r.seg = alc_pkg::SEG_LOW;
				acc = ((C1_BB * b) << 16) - C1_IR * b * longint'(pow14_rom[idx]);
			end else if (100 * f <= 61 * b) begin
				r.seg = alc_pkg::SEG_MID;
				acc = (C2_BB * b - C2_IR * f) * 65536;
			end else if (5 * f <= 4 * b) begin
				r.seg = alc_pkg::SEG_HIGH;
				acc = (C3_BB * b - C3_IR * f) * 65536;
			end else if (10 * f <= 13 * b) begin
				r.seg = alc_pkg::SEG_TOP;
				acc = (C4_BB * b - C4_IR * f) * 65536;
			end
		end
		// Clamp negatives to zero, round half up from Q48, saturate
		if (r.seg != alc_pkg::SEG_NONE && acc > 0) begin
			lux = (acc + (longint'(1) << (47 - LFRAC))) >> (48 - LFRAC);
			if (lux > LUX_CEIL) begin
				lux = LUX_CEIL;
			end
			r.lux = lux[18:0];
		end
		return r;
	endfunction

	// Retire result beats against the oldest prediction, then queue new input beats
	always @(posedge clk or negedge arst_n) begin : track
		lux_pred_t   want;
		logic [18:0] got_lux;
		logic [2:0]  got_seg;
		int          errs;
		if (!arst_n) begin
			lux_pred_q.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (m_tvalid && m_tready) begin
				got_lux = m_tdata[18:0];
				got_seg = m_tdata[21:19];
				if (lux_pred_q.size() == 0) begin
					errs++;
					if (reports < MAX_REPORTS) begin
						$display("%0t: unexpected result beat, expected none, actual lux_q8=%0d segment=%0d",
							$time, got_lux, got_seg);
					end
				end else begin
					want = lux_pred_q.pop_front();
					if (got_lux !== want.lux) begin
						errs++;
						if (reports < MAX_REPORTS) begin
							$display("%0t: lux_q8 expected %0d actual %0d", $time, want.lux, got_lux);
						end
					end
					if (got_seg !== want.seg) begin
						errs++;
						if (reports < MAX_REPORTS) begin
							$display("%0t: segment expected %0d actual %0d", $time, want.seg, got_seg);
						end
					end
					if (m_tdata[23:22] !== 2'b00) begin
						errs++;
						if (reports < MAX_REPORTS) begin
							$display("%0t: pad bits expected 0 actual %b", $time, m_tdata[23:22]);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				lux_pred_q.push_back(predict_lux(s_tdata[15:0], s_tdata[31:16]));
			end
			// keep the log readable when everything goes wrong
			reports = reports + errs;
			mismatches <= mismatches + errs;
			outstanding <= lux_pred_q.size();
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int N_RAND = 1600;
	localparam int N_DIR  = 19;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // broadband_count[15:0], infrared_count[31:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // lux_q8[18:0], segment[21:19], zero pad[23:22]
	logic        quiet = 1'b0;
	int          rx_beats = 0;
	int          mismatches;
	int          outstanding;

	// Edge cases: zero channels, full scale, each segment bound on and past it
	logic [15:0] dir_bb [0:N_DIR-1] = '{
		16'd0, 16'd0, 16'd65535, 16'd65535, 16'd1, 16'd2, 16'd65535, 16'd65535, 16'd65534,
		16'd100, 16'd100, 16'd5, 16'd50000, 16'd10, 16'd10, 16'd1, 16'd65535, 16'd40000,
		16'd3
	};
	logic [15:0] dir_ir [0:N_DIR-1] = '{
		16'd0, 16'd65535, 16'd0, 16'd65535, 16'd1, 16'd1, 16'd1, 16'd32767, 16'd32767,
		16'd61, 16'd62, 16'd4, 16'd40001, 16'd13, 16'd14, 16'd65535, 16'd50000, 16'd13000,
		16'd2
	};

	ambient_light_lux_calc u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lux_scoreboard u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run
	initial begin
		#2000000;
		$display("ambient_light_lux_calc verification failed");
		$finish;
	end

	// Count result beats for the receiver's mid-run hold-off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			rx_beats <= rx_beats + 1;
		end
	end

	// Receiver: long hold-off after reset and mid-run, short random stalls otherwise
	initial begin : rx_side
		int   hold_left;
		logic mid_done;
		m_tready = 1'b0;
		hold_left = 100;
		mid_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!mid_done && rx_beats >= 700) begin
				mid_done = 1'b1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				hold_left = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one beat and hold it until taken; returns on the following falling edge
	task automatic send_beat(input logic [15:0] bb_cnt, input logic [15:0] ir_cnt);
		s_tdata <= {ir_cnt, bb_cnt};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stop offering until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	initial begin : tx_side
		int bb;
		int ir;
		int lo;
		int hi;
		int mode;
		int num;
		int den;
		int m;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats back to back, into the receiver's opening hold-off
		for (int i = 0; i < N_DIR; i++) begin
			send_beat(dir_bb[i], dir_ir[i]);
		end
		drain_results();

		// Random beats, mostly steered into one segment each
		for (int k = 0; k < N_RAND; k++) begin
			quiet <= (k >= N_RAND - 200);
			if (k == N_RAND / 2) begin
				drain_results();
			end
			bb = $urandom_range(0, 65535) >> $urandom_range(0, 15);
			ir = $urandom_range(0, 65535);
			lo = 1;
			hi = 0;
			mode = $urandom_range(0, 9);
			case (mode)
				0, 1: begin
					lo = 1;
					hi = bb / 2;
				end
				2: begin
					lo = bb / 2 + 1;
					hi = (61 * bb) / 100;
				end
				3: begin
					lo = (61 * bb) / 100 + 1;
					hi = (4 * bb) / 5;
				end
				4, 5: begin
					lo = (4 * bb) / 5 + 1;
					hi = (13 * bb) / 10;
					if (hi > 65535) begin
						hi = 65535;
					end
				end
				6: begin
					// land on a segment bound or one count either side
					case ($urandom_range(0, 3))
						0: begin num = 1; den = 2; end
						1: begin num = 61; den = 100; end
						2: begin num = 4; den = 5; end
						default: begin num = 13; den = 10; end
					endcase
					m = $urandom_range(1, 65534 / ((num > den) ? num : den));
					bb = den * m;
					ir = num * m + $urandom_range(0, 2) - 1;
				end
				7: begin
					bb = $urandom_range(0, 65535);
				end
				8: begin
					if ($urandom_range(0, 1) == 0) begin
						bb = 0;
					end else begin
						ir = 0;
					end
				end
				default: begin
					// bright scene, low infrared share
					bb = $urandom_range(32768, 65535);
					lo = 1;
					hi = bb / 2;
				end
			endcase
			if (lo <= hi) begin
				ir = $urandom_range(lo, hi);
			end
			send_beat(16'(bb), 16'(ir));
			if (!quiet && $urandom_range(0, 5) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
		end

		// Let the pipeline empty, then give the verdict
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("ambient_light_lux_calc verification clean");
		end else begin
			$display("ambient_light_lux_calc verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/alc_pkg.sv
sv/ambient_light_lux_calc.sv
test/lux_scoreboard.sv
test/tb_top.sv
